### rtl/core/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/core/itra_pkg.sv
// Shared constants, types and the digit-to-character function for integer to ASCII conversion
package itra_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int SLICE_BITS     = 8;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic               bad_radix;
        logic               negative;
        logic [RADIX_W-1:0] radix;
    } t_itra_ctl;

    function automatic logic [CHAR_W-1:0] itra_digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else begin
            ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return ch;
    endfunction

endpackage

### rtl/core/integer_to_radix_ascii.sv
// Converts an integer to ASCII text in a radix of 2..36, one character per result item.
// Each digit comes from the shared divider that resolves 8 quotient bits per cycle, then the
// characters (plus one for '-') go out at one per cycle while the output is not stalled.
// A 2-entry queue lets the next item wait during conversion.
// Reset (synchronous, active low) empties the queue and the output register; no clearing pass.
`include "assert_macros.svh"

module integer_to_radix_ascii #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic                         i_signed_mode,
    input  logic [itra_pkg::RADIX_W-1:0] i_radix,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [itra_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last,
    output logic                         o_bad_radix
);
    import itra_pkg::*;

    logic                  push;
    t_itra_ctl             push_ctl;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  q_full;
    logic                  q_valid;
    t_itra_ctl             q_ctl;
    logic [VALUE_BITS-1:0] q_mag;
    logic                  q_pop;

    itra_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_signed_mode (i_signed_mode),
        .i_radix       (i_radix),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_ctl         (push_ctl),
        .o_mag         (push_mag)
    );

    itra_queue #(
        .VALUE_BITS (VALUE_BITS),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (push_ctl),
        .i_mag   (push_mag),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ctl   (q_ctl),
        .o_mag   (q_mag),
        .i_pop   (q_pop)
    );

    itra_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ctl     (q_ctl),
        .i_q_mag     (q_mag),
        .o_q_pop     (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

    `ASSERT_CLK(a_push_lands, i_clk, i_rst_n, (i_valid && !o_stall) |=> q_valid)
    `ASSERT_NEVER(a_minus_last, i_clk, i_rst_n, o_valid && o_last && o_character == CHAR_MINUS)
    `ASSERT_CLK(a_bad_form, i_clk, i_rst_n, (o_valid && o_bad_radix) |-> (o_last && o_character == CHAR_NONE))
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && !q_valid)

endmodule

### rtl/core/itra_front.sv
// Front end: accepts items, checks the radix, and forms sign and magnitude
module itra_front #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic                          i_signed_mode,
    input  logic [itra_pkg::RADIX_W-1:0]  i_radix,
    input  logic                          i_q_full,
    output logic                          o_push,
    output itra_pkg::t_itra_ctl           o_ctl,
    output logic [VALUE_BITS-1:0]         o_mag
);
    import itra_pkg::*;

    logic negative;

    assign negative = i_signed_mode & i_value[VALUE_BITS-1];

    assign o_stall          = i_q_full;
    assign o_push           = i_valid & ~i_q_full;
    assign o_ctl.bad_radix  = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign o_ctl.negative   = negative;
    assign o_ctl.radix      = i_radix;
    // magnitude of the most negative value still fits: 2^(VALUE_BITS-1)
    assign o_mag = negative ? VALUE_BITS'(~i_value + 1'b1) : i_value;

endmodule

### rtl/core/itra_queue.sv
// Short job queue between the front end and the conversion back end
module itra_queue #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF,
    parameter int DEPTH      = itra_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  itra_pkg::t_itra_ctl   i_ctl,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_full,
    output logic                  o_valid,
    output itra_pkg::t_itra_ctl   o_ctl,
    output logic [VALUE_BITS-1:0] o_mag,
    input  logic                  i_pop
);
    import itra_pkg::*;

    localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);

    t_itra_ctl             r_ctl [DEPTH];
    logic [VALUE_BITS-1:0] r_mag [DEPTH];
    logic [QAW-1:0]        r_wr_ptr;
    logic [QAW-1:0]        r_rd_ptr;
    logic [QCW-1:0]        r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == QCW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ctl   = r_ctl[r_rd_ptr];
    assign o_mag   = r_mag[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl[r_wr_ptr] <= i_ctl;
            r_mag[r_wr_ptr] <= i_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/itra_back.sv
// Back end: repeated division into a digit store, then character emission (or one null marker for a bad radix)
module itra_back #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  itra_pkg::t_itra_ctl          i_q_ctl,
    input  logic [VALUE_BITS-1:0]        i_q_mag,
    output logic                         o_q_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [itra_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last,
    output logic                         o_bad_radix
);
    import itra_pkg::*;

    localparam int NS    = (VALUE_BITS + SLICE_BITS - 1) / SLICE_BITS;
    localparam int PW    = NS * SLICE_BITS;
    localparam int SW    = (NS > 1) ? $clog2(NS) : 1;
    localparam int DEPTH = VALUE_BITS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIV,
        ST_LOAD,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [RADIX_W-1:0]   r_radix;
    logic                 r_negative;
    logic [PW-1:0]        r_dvd;
    logic [PW-1:0]        r_quo;
    logic [DIGIT_W-1:0]   r_rem;
    logic [SW-1:0]        r_slice;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;
    logic [DIGIT_W-1:0]   r_digits [DEPTH];
    logic [DIGIT_W-1:0]   r_rd_digit;
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic                 r_bad;

    logic [DIGIT_W-1:0]   n_rem;
    logic [DIGIT_W:0]     trial;
    logic [SLICE_BITS-1:0] qbits;
    logic [PW-1:0]        n_quo;
    logic                 slice_last;
    logic                 slot_free;
    logic                 emit_now;
    logic                 mem_we;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    // restoring division, one slice of quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        qbits = '0;
        trial = '0;
        for (int k = 0; k < SLICE_BITS; k++) begin
            trial = {n_rem, r_dvd[PW-1-k]};
            if (trial >= {1'b0, r_radix}) begin
                n_rem = DIGIT_W'(trial - {1'b0, r_radix});
                qbits[SLICE_BITS-1-k] = 1'b1;
            end else begin
                n_rem = trial[DIGIT_W-1:0];
            end
        end
    end

    assign n_quo      = (r_quo << SLICE_BITS) | PW'(qbits);
    assign slice_last = (r_slice == SW'(NS - 1));
    assign slot_free  = ~r_out_valid | ~i_stall;
    assign emit_now   = slot_free &
                        ((r_state == ST_BAD) || (r_state == ST_SIGN) || (r_state == ST_EMIT));
    assign o_q_pop    = (r_state == ST_IDLE) & i_q_valid;
    assign mem_we     = (r_state == ST_DIV) & slice_last;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx - 1'b1;
        if (r_state == ST_LOAD) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_count - 1'b1);
        end else if (r_state == ST_EMIT && slot_free && r_idx != '0) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_digits[r_count[AW-1:0]] <= n_rem;
        end
        if (rd_en) begin
            r_rd_digit <= r_digits[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_radix    <= i_q_ctl.radix;
                        r_negative <= i_q_ctl.negative;
                        r_dvd      <= PW'(i_q_mag);
                        r_rem      <= '0;
                        r_slice    <= '0;
                        r_count    <= '0;
                        r_state    <= i_q_ctl.bad_radix ? ST_BAD : ST_DIV;
                    end
                end
                ST_BAD: begin
                    if (slot_free) begin
                        r_char      <= CHAR_NONE;
                        r_last      <= 1'b1;
                        r_bad       <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    r_quo <= n_quo;
                    if (slice_last) begin
                        // digit done: restart on the quotient or finish
                        r_count <= r_count + 1'b1;
                        r_dvd   <= n_quo;
                        r_rem   <= '0;
                        r_slice <= '0;
                        if (n_quo == '0) begin
                            r_state <= ST_LOAD;
                        end
                    end else begin
                        r_dvd   <= r_dvd << SLICE_BITS;
                        r_rem   <= n_rem;
                        r_slice <= r_slice + 1'b1;
                    end
                end
                ST_LOAD: begin
                    r_idx   <= AW'(r_count - 1'b1);
                    r_state <= r_negative ? ST_SIGN : ST_EMIT;
                end
                ST_SIGN: begin
                    if (slot_free) begin
                        r_char      <= CHAR_MINUS;
                        r_last      <= 1'b0;
                        r_bad       <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_char      <= itra_digit_char(r_rd_digit);
                        r_last      <= (r_idx == '0);
                        r_bad       <= 1'b0;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;

endmodule

### tb/tb_integer_to_radix_ascii.sv
// Testbench for integer_to_radix_ascii: directed and random items checked against a local model
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;

    import itra_pkg::*;

    localparam int VBITS     = 32;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_LEN = 250;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
        logic              bad;
    } t_text_char;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [VBITS-1:0]   i_value       = '0;
    logic               i_signed_mode = 1'b0;
    logic [RADIX_W-1:0] i_radix       = '0;
    logic               i_stall       = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;
    logic               o_bad_radix;

    t_text_char pending_chars[$];
    int         err_cnt     = 0;
    bit         sender_idle = 1'b1;
    bit         recv_idle   = 1'b1;
    bit         hold_req    = 1'b0;
    int         hold_left   = 0;

    integer_to_radix_ascii #(
        .VALUE_BITS (VBITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_signed_mode (i_signed_mode),
        .i_radix       (i_radix),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last        (o_last),
        .o_bad_radix   (o_bad_radix)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Expected text of one conversion, most significant character first
    function automatic void predict_text(input logic [VBITS-1:0] v, input logic sm,
                                         input logic [RADIX_W-1:0] r);
        logic [VBITS:0]     mag;
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] digit_list[$];
        logic               neg;
        t_text_char         tc;
        if (r < RADIX_MIN || r > RADIX_MAX) begin
            tc.ch      = CHAR_NONE;
            tc.is_last = 1'b1;
            tc.bad     = 1'b1;
            pending_chars.push_back(tc);
            return;
        end
        neg = sm && v[VBITS-1];
        // one bit wider so the most negative value keeps its full magnitude
        mag = {1'b0, neg ? (~v + 1'b1) : v};
        do begin
            d   = DIGIT_W'(mag % (VBITS+1)'(r));
            mag = mag / (VBITS+1)'(r);
            digit_list.push_front(d);
        end while (mag != 0);
        tc.bad = 1'b0;
        if (neg) begin
            tc.ch      = CHAR_MINUS;
            tc.is_last = 1'b0;
            pending_chars.push_back(tc);
        end
        foreach (digit_list[i]) begin
            if (digit_list[i] < DEC_DIGITS) begin
                tc.ch = CHAR_ZERO + CHAR_W'(digit_list[i]);
            end else begin
                tc.ch = CHAR_A + CHAR_W'(digit_list[i] - DEC_DIGITS);
            end
            tc.is_last = (i == digit_list.size() - 1);
            pending_chars.push_back(tc);
        end
    endfunction

    // Predict on every accepted input item
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_text(i_value, i_signed_mode, i_radix);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : char_check
        t_text_char exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected result: character %h last %b bad_radix %b",
                       o_character, o_last, o_bad_radix);
                err_cnt++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_character !== exp_c.ch) begin
                    $error("character: expected %h, actual %h", exp_c.ch, o_character);
                    err_cnt++;
                end
                if (o_last !== exp_c.is_last) begin
                    $error("last: expected %b, actual %b", exp_c.is_last, o_last);
                    err_cnt++;
                end
                if (o_bad_radix !== exp_c.bad) begin
                    $error("bad_radix: expected %b, actual %b", exp_c.bad, o_bad_radix);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_idle && ($urandom_range(99) < 6);
        end
    end

    // Offer one item from a falling edge until it is taken; return on a falling edge
    task automatic send_item(input logic [VBITS-1:0] v, input logic sm,
                             input logic [RADIX_W-1:0] r);
        if (sender_idle && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= v;
        i_signed_mode <= sm;
        i_radix       <= r;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic logic [VBITS-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VBITS'($urandom_range(0, 40));
            2:       return {1'b1, {(VBITS-1){1'b0}}};
            3:       return {1'b0, {(VBITS-1){1'b1}}};
            4:       return '1;
            5:       return -VBITS'($urandom_range(1, 100));
            default: return VBITS'($urandom);
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
                0:       return '0;
                1:       return RADIX_W'(1);
                default: return RADIX_W'($urandom_range(37, 63));
            endcase
        end
        return RADIX_W'($urandom_range(2, 36));
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_item(pick_value(), 1'($urandom), pick_radix());
    endtask

    task automatic test_directed();
        send_item('0, 1'b0, RADIX_W'(10));
        send_item('0, 1'b1, RADIX_W'(2));
        send_item('1, 1'b0, RADIX_W'(2));
        send_item('1, 1'b0, RADIX_W'(16));
        send_item('1, 1'b0, RADIX_W'(36));
        send_item('1, 1'b1, RADIX_W'(10));
        send_item(32'h8000_0000, 1'b1, RADIX_W'(2));
        send_item(32'h8000_0000, 1'b1, RADIX_W'(10));
        send_item(32'h8000_0000, 1'b1, RADIX_W'(16));
        send_item(32'h8000_0000, 1'b0, RADIX_W'(10));
        send_item(32'h7FFF_FFFF, 1'b1, RADIX_W'(36));
        send_item(32'd35, 1'b0, RADIX_W'(36));
        send_item(32'd10, 1'b0, RADIX_W'(11));
        send_item(32'd1, 1'b1, RADIX_W'(2));
        send_item(32'd12345, 1'b1, RADIX_W'(8));
        // bad radix values; the conversion after them must be unaffected
        send_item(32'd77, 1'b0, RADIX_W'(0));
        send_item(32'd77, 1'b1, RADIX_W'(1));
        send_item(32'd77, 1'b0, RADIX_W'(37));
        send_item('1, 1'b1, RADIX_W'(63));
        send_item(32'hFFFF_FF85, 1'b1, RADIX_W'(7));
    endtask

    task automatic test_random_mix();
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
        send_random(200);
    endtask

    task automatic test_back_pressure();
        sender_idle = 1'b0;
        hold_req    = 1'b1;
        repeat (30) send_item(VBITS'($urandom), 1'($urandom), RADIX_W'(16));
        sender_idle = 1'b1;
    endtask

    task automatic test_no_idle();
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
        send_random(100);
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
    endtask

    task automatic test_random_tail();
        send_random(100);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_mix();
        test_back_pressure();
        test_no_idle();
        test_random_tail();

        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d expected characters never arrived", pending_chars.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/itra_pkg.sv
rtl/core/itra_front.sv
rtl/core/itra_queue.sv
rtl/core/itra_back.sv
rtl/core/integer_to_radix_ascii.sv
tb/tb_integer_to_radix_ascii.sv
